>>> rtl/core/numeric_char_reference_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the numeric character reference parser
// ----------------------------------------------------------------------------
`ifndef NUMERIC_CHAR_REFERENCE_PARSER_DEFINES_SVH
`define NUMERIC_CHAR_REFERENCE_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define NCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ncr: same-cycle rule broken");

// Next-cycle implication, checked on every rising edge out of reset.
`define NCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ncr: next-cycle rule broken");

`endif

>>> rtl/core/ncr_pkg.sv
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared types, codes and digit decode for the numeric reference parser.
// ----------------------------------------------------------------------------
package ncr_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int CNT_W          = 4;
  localparam int CODE_W         = 16;
  localparam int STAT_W         = 3;
  localparam int PH_W           = 2;

  // Phase codes
  localparam logic [PH_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PH_W-1:0] PH_SECOND = 2'd1;
  localparam logic [PH_W-1:0] PH_THIRD  = 2'd2;
  localparam logic [PH_W-1:0] PH_DIGITS = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EARLY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADCHAR = 3'd2;
  localparam logic [STAT_W-1:0] ST_TOOMANY = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic              hex_mode;
    logic [CNT_W-1:0]  digit_count;
    logic [CODE_W-1:0] accumulator;
    logic              overflowed;
  } ncr_state_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] char_in;
    logic       start_req;
  } ncr_req_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code_point;
    logic [STAT_W-1:0] status;
  } ncr_result_t;

  // Digit decode: bit 4 is the valid flag, bits 3:0 the digit value.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (hex && c >= CH_LOW_A && c <= CH_LOW_F) begin
      r = {1'b1, 4'(c - CH_LOW_A + 8'd10)};
    end else if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
      r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ncr_in_stage.sv
// ----------------------------------------------------------------------------
// ncr_in_stage
// Input register: captures one request byte and holds it until decoded.
// ----------------------------------------------------------------------------
module ncr_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      char_in,
  input  logic            start_req,
  input  logic            advance,
  output ncr_pkg::ncr_req_t req
);
  import ncr_pkg::*;

  logic       vld;
  logic [7:0] char_r;
  logic       start_r;

  // Hold while a request waits and the decode cannot advance.
  assign in_stall = vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!in_stall) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r  <= char_in;
      start_r <= start_req;
    end
  end

  assign req = '{vld: vld, char_in: char_r, start_req: start_r};

endmodule

>>> rtl/core/ncr_decode.sv
// ----------------------------------------------------------------------------
// ncr_decode
// One-byte step of the reference decoder: next state and optional result.
// ----------------------------------------------------------------------------
module ncr_decode #(
  parameter int MAX_DIGITS = ncr_pkg::MAX_DIGITS_DEF
) (
  input  ncr_pkg::ncr_req_t    req,
  input  ncr_pkg::ncr_state_t  cur,
  output ncr_pkg::ncr_state_t  nxt,
  output ncr_pkg::ncr_result_t res
);
  import ncr_pkg::*;

  localparam logic [CNT_W-1:0] DIGIT_LIMIT = CNT_W'(MAX_DIGITS);

  logic [7:0]        c;
  logic              hex_eff;
  logic [4:0]        dv;
  logic [19:0]       mac;
  logic [CNT_W-1:0]  cnt_inc;
  ncr_state_t        dig_st;
  ncr_result_t       dig_res;

  assign c = req.char_in;

  // The hex select byte sets hex mode for the bytes after it, not its own step.
  assign hex_eff = cur.hex_mode;
  assign dv      = digit_value(c, hex_eff);
  assign cnt_inc = cur.digit_count + CNT_W'(1);

  // Multiply-add: x16 is a shift, x10 is (x8 + x2).
  always_comb begin
    if (hex_eff) begin
      mac = {cur.accumulator, 4'd0} + 20'(dv[3:0]);
    end else begin
      mac = {1'b0, cur.accumulator, 3'd0} + {3'd0, cur.accumulator, 1'b0}
          + 20'(dv[3:0]);
    end
  end

  // Digit-phase byte handling, shared by third byte and digit phase.
  always_comb begin
    dig_st  = cur;
    dig_res = '{vld: 1'b1, code_point: '0, status: ST_OK};
    dig_st.phase = PH_IDLE;
    if (c == CH_SEMI) begin
      if (cur.overflowed) begin
        dig_res.status = ST_RANGE;
      end else begin
        dig_res.code_point = cur.accumulator;
      end
    end else if (c == CH_NUL) begin
      dig_res.status = ST_EARLY;
    end else if (c > CH_ASCII_MAX || !dv[4]) begin
      dig_res.status = ST_BADCHAR;
    end else begin
      dig_st.accumulator = mac[15:0];
      dig_st.overflowed  = cur.overflowed | (mac[19:16] != 4'd0);
      dig_st.digit_count = cnt_inc;
      if (cnt_inc >= DIGIT_LIMIT) begin
        dig_res.status = ST_TOOMANY;
      end else begin
        dig_res.vld   = 1'b0;
        dig_st.phase  = PH_DIGITS;
      end
    end
  end

  always_comb begin
    nxt = cur;
    res = '{vld: 1'b0, code_point: '0, status: ST_OK};
    if (req.start_req) begin
      nxt = '{phase: PH_SECOND, hex_mode: 1'b0, digit_count: '0,
              accumulator: '0, overflowed: 1'b0};
    end else begin
      unique case (cur.phase)
        PH_SECOND: nxt.phase = PH_THIRD;
        PH_THIRD: begin
          if (c == CH_NUL) begin
            nxt.phase = PH_IDLE;
            res = '{vld: 1'b1, code_point: '0, status: ST_EARLY};
          end else if (c == CH_LOW_X || c == CH_UP_X) begin
            nxt.phase    = PH_DIGITS;
            nxt.hex_mode = 1'b1;
          end else begin
            nxt = dig_st;
            res = dig_res;
          end
        end
        PH_DIGITS: begin
          nxt = dig_st;
          res = dig_res;
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ncr_out_stage.sv
// ----------------------------------------------------------------------------
// ncr_out_stage
// Result register: holds one decoded result until the consumer takes it.
// ----------------------------------------------------------------------------
module ncr_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  ncr_pkg::ncr_result_t     res,
  output logic                     room,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ncr_pkg::CODE_W-1:0] code_point,
  output logic [ncr_pkg::STAT_W-1:0] status
);
  import ncr_pkg::*;

  // Room when empty or when the held result leaves this edge.
  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= fire && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (room && fire && res.vld) begin
      code_point <= res.code_point;
      status     <= res.status;
    end
  end

endmodule

>>> rtl/core/numeric_char_reference_parser.sv
// ----------------------------------------------------------------------------
// numeric_char_reference_parser: "&#..;" / "&#x..;" byte-stream decoder.
// Path: accepted byte in the input reg, then its decoded result in the result reg.
// Throughput: one byte per cycle, set by the single decode step, unless output stalls.
// Reset: synchronous, active high; clears valids and parser state to idle.
// ----------------------------------------------------------------------------
module numeric_char_reference_parser #(
  parameter int MAX_DIGITS = ncr_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 char_in,
  input  logic                       start_req,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ncr_pkg::CODE_W-1:0] code_point,
  output logic [ncr_pkg::STAT_W-1:0] status
);
  import ncr_pkg::*;

  ncr_req_t    req;
  ncr_state_t  st;
  ncr_state_t  st_next;
  ncr_result_t res;
  logic        room;
  logic        fire;

  // A held request is decoded when the result register has room; every
  // request advances the parser state, results are optional.
  assign fire = req.vld && room;

  ncr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .start_req (start_req),
    .advance   (room),
    .req       (req)
  );

  ncr_decode #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dec (
    .req (req),
    .cur (st),
    .nxt (st_next),
    .res (res)
  );

  // Parser state: advance only on a decoded request, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, hex_mode: 1'b0, digit_count: '0,
              accumulator: '0, overflowed: 1'b0};
    end else if (fire) begin
      st <= st_next;
    end
  end

  ncr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .res        (res),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .status     (status)
  );

endmodule

>>> rtl/core/ncr_checker.sv
// ----------------------------------------------------------------------------
// ncr_checker
// Port-level checks for the numeric reference parser, bound to the top.
// ----------------------------------------------------------------------------
`include "numeric_char_reference_parser_defines.svh"

module ncr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [7:0]                 char_in,
  input logic                       start_req,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ncr_pkg::CODE_W-1:0] code_point,
  input logic [ncr_pkg::STAT_W-1:0] status
);
  import ncr_pkg::*;

  // Hold a stalled result unchanged.
  `NCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({code_point, status}))

  // Status is always one of the defined codes.
  `NCR_ASSERT_NOW(a_status_range, out_valid, status <= ST_RANGE)

  // Every failure carries a zero code point.
  `NCR_ASSERT_NOW(a_fail_zero, out_valid && status != ST_OK, code_point == '0)

  // Input stalls only behind a stalled result.
  `NCR_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall)

  // Hold a stalled request unchanged.
  `NCR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable({char_in, start_req}))

endmodule

bind numeric_char_reference_parser ncr_checker u_ncr_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for numeric_char_reference_parser
// Sends "&#..;" and "&#x..;" byte streams, well formed and broken, through
// the request channel with random bursts, gaps and result stalls. A local
// decoder predicts each result and a checker compares every result that
// leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncr_pkg::*;

  localparam int TB_MAX_DIGITS = MAX_DIGITS_DEF;
  localparam int ITEM_TARGET   = 1550;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic [7:0] AMP_CH  = 8'h26;
  localparam logic [7:0] HASH_CH = 8'h23;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_EVERY_THIRD,
    RX_HEAVY
  } rx_mode_t;

  typedef struct packed {
    logic [CODE_W-1:0] cp;
    logic [STAT_W-1:0] st;
  } code_result_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [7:0]        char_in   = 8'h00;
  logic              start_req = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] code_point;
  logic [STAT_W-1:0] status;

  numeric_char_reference_parser dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .start_req  (start_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .status     (status)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Decoder state kept by the testbench, advanced on every accepted request
  // --------------------------------------------------------------------------
  logic [PH_W-1:0]   ref_phase = PH_IDLE;
  logic              ref_hex   = 1'b0;
  logic [CNT_W-1:0]  ref_ndig  = '0;
  logic [CODE_W-1:0] ref_acc   = '0;
  logic              ref_big   = 1'b0;

  code_result_t awaited_codes[$];

  int errors        = 0;
  int bytes_taken   = 0;
  int codes_checked = 0;
  int status_seen[0:4];
  int restarts_sent = 0;

  // Sender burst control
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Long receiver hold-off, asked for by a test and counted by the receiver
  int hold_asked  = 0;
  int hold_served = 0;

  // Take one byte while inside the digit string: ';' closes the reference,
  // anything else must be a digit of the current radix.
  function automatic void take_digit(input logic [7:0] c, output logic fire,
                                     output code_result_t r);
    logic [7:0]  folded;
    logic        is_digit;
    logic [3:0]  nib;
    logic [19:0] grown;
    fire     = 1'b1;
    r.cp     = '0;
    r.st     = ST_OK;
    is_digit = 1'b0;
    nib      = '0;
    // fold upper case letters onto lower case for the hex check
    folded   = c | 8'h20;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      is_digit = 1'b1;
      nib      = 4'(c - CH_ZERO);
    end else if (ref_hex && folded >= CH_LOW_A && folded <= CH_LOW_F) begin
      is_digit = 1'b1;
      nib      = 4'(folded - CH_LOW_A + 8'd10);
    end
    if (c == CH_SEMI) begin
      r.st = ref_big ? ST_RANGE : ST_OK;
      r.cp = ref_big ? '0 : ref_acc;
    end else if (c == CH_NUL) begin
      r.st = ST_EARLY;
    end else if (c > CH_ASCII_MAX || !is_digit) begin
      r.st = ST_BADCHAR;
    end else begin
      grown = {4'd0, ref_acc} * (ref_hex ? 20'd16 : 20'd10) + 20'(nib);
      if (grown > 20'hFFFF) ref_big = 1'b1;
      ref_acc  = grown[15:0];
      ref_ndig = ref_ndig + 1'b1;
      if (ref_ndig >= TB_MAX_DIGITS) r.st = ST_TOOMANY;
      else fire = 1'b0;
    end
    if (fire) ref_phase = PH_IDLE;
  endfunction

  // Advance the decoder by one request; fire says whether a result is due.
  function automatic void decode_byte(input logic [7:0] c, input logic s,
                                      output logic fire, output code_result_t r);
    fire = 1'b0;
    r    = '0;
    if (s) begin
      // a start always restarts, whatever the phase and the byte
      ref_phase = PH_SECOND;
      ref_hex   = 1'b0;
      ref_ndig  = '0;
      ref_acc   = '0;
      ref_big   = 1'b0;
    end else begin
      case (ref_phase)
        PH_SECOND: begin
          // the '#' position is taken unchecked
          ref_phase = PH_THIRD;
        end
        PH_THIRD: begin
          if (c == CH_NUL) begin
            fire      = 1'b1;
            r.st      = ST_EARLY;
            ref_phase = PH_IDLE;
          end else begin
            ref_phase = PH_DIGITS;
            if (c == CH_LOW_X || c == CH_UP_X) ref_hex = 1'b1;
            else take_digit(c, fire, r);
          end
        end
        PH_DIGITS: begin
          take_digit(c, fire, r);
        end
        default: begin
          // idle: drop the byte
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request monitor: predict at every accepted request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic         fire;
    code_result_t r;
    if (!rst && in_valid && !in_stall) begin
      decode_byte(char_in, start_req, fire, r);
      if (fire) awaited_codes.push_back(r);
      bytes_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    code_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_codes.size() == 0) begin
        $display("%0t: unexpected result code_point=%h status=%0d",
                 $time, code_point, status);
        errors++;
      end else begin
        want = awaited_codes.pop_front();
        if (code_point !== want.cp) begin
          $display("%0t: code_point mismatch, expected %h, actual %h",
                   $time, want.cp, code_point);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.st, status);
          errors++;
        end
        codes_checked++;
        if (want.st <= ST_RANGE) status_seen[want.st]++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: long hold-off on request, otherwise a changing stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    static rx_mode_t rx_mode   = RX_FLOW;
    static int       mode_left = 0;
    static int       hold_left = 0;
    static int       tick      = 0;
    tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_FLOW:        out_stall <= 1'b0;
        RX_LIGHT:       out_stall <= ($urandom_range(0, 99) < 25);
        RX_EVERY_THIRD: out_stall <= (tick % 3 == 0);
        default:        out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    static int quiet = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one request, with bursts and gaps, returning at its acceptance
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic s);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid  <= 1'b0;
      char_in   <= 8'($urandom_range(0, 255));
      start_req <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    char_in   <= c;
    start_req <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send a string; the first byte carries start when lead_start is set.
  task automatic send_text(input string txt, input bit lead_start = 1'b1);
    for (int i = 0; i < txt.len(); i++) begin
      send_byte(txt[i], lead_start && (i == 0));
    end
  endtask

  // Wait until every predicted result has arrived, then a little longer.
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_well_formed();
    send_text("&#65;");
    send_text("&#x4a;");
    send_text("&#XfF;");
    send_text("&#00065535;");
    send_text("&#x0000FFFF;");
    // empty digit strings give code 0 with status ok
    send_text("&#;");
    send_text("&#x;");
  endtask

  task automatic test_failures();
    // terminator as third byte and inside the digits
    send_text("&#");
    send_byte(CH_NUL, 1'b0);
    send_text("&#1");
    send_byte(CH_NUL, 1'b0);
    // byte above 127, non-digits for each radix
    send_text("&#12");
    send_byte(8'hFF, 1'b0);
    send_text("&#x1g;");
    send_text("&#1a;");
    // digit limit, and values past 0xFFFF
    send_text("&#0123456789");
    send_text("&#123456789;");
    send_text("&#65536;");
    send_text("&#x10000;");
  endtask

  task automatic test_restart_and_idle();
    // bytes while idle are dropped
    send_byte("Q", 1'b0);
    send_byte(8'hFF, 1'b0);
    // the second byte is not checked, not even for a terminator
    send_byte(AMP_CH, 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_text("7;", 1'b0);
    // a start in the middle of a reference restarts it
    send_text("&#12");
    send_text("&#x41;");
    // the start byte itself may be anything
    send_byte(CH_NUL, 1'b1);
    send_text("#5;", 1'b0);
    // bytes after a result are dropped until the next start
    send_text("&#9;");
    send_text(";9x", 1'b0);
  endtask

  task automatic send_random_ref();
    logic       hex;
    int         ndig;
    int         pick;
    logic [3:0] nib;
    logic [7:0] ch;
    send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : AMP_CH, 1'b1);
    send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : HASH_CH, 1'b0);
    hex = ($urandom_range(0, 9) < 4);
    if (hex) send_byte($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X, 1'b0);
    // mostly short digit strings, now and then up to and past the limit
    ndig = ($urandom_range(0, 19) < 16) ? $urandom_range(0, 6)
                                       : $urandom_range(7, TB_MAX_DIGITS + 1);
    repeat (ndig) begin
      nib = hex ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
      if (nib < 10) ch = CH_ZERO + 8'(nib);
      else ch = ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + 8'(nib) - 8'd10;
      send_byte(ch, 1'b0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 78) ch = CH_SEMI;
    else if (pick < 84) ch = CH_NUL;
    else if (pick < 90) ch = 8'($urandom_range(128, 255));
    else ch = 8'($urandom_range(1, 127));
    // leave a few references open so that the next start cuts them short
    if (pick < 96) send_byte(ch, 1'b0);
    else restarts_sent++;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_random_refs();
    while (bytes_taken < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_ref();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    // hold the result side off and keep offering short references
    gaps_on = 1'b0;
    hold_asked++;
    repeat (40) begin
      if ($urandom_range(0, 1) != 0) send_text("&#7;");
      else send_text("&#;");
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_well_formed();
    test_failures();
    test_restart_and_idle();
    drain();
    test_backpressure();
    drain();
    test_random_refs();
    drain();
    $display("Covered %0d requests and %0d results, %0d references cut by a restart",
             bytes_taken, codes_checked, restarts_sent);
    $display("Statuses: ok %0d, early %0d, bad char %0d, too many %0d, range %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ncr_pkg.sv
rtl/core/ncr_in_stage.sv
rtl/core/ncr_decode.sv
rtl/core/ncr_out_stage.sv
rtl/core/numeric_char_reference_parser.sv
rtl/core/ncr_checker.sv
tb/tb.sv
